### sv/pmca_pkg.sv
// Shared types, codes and helpers of the prefix match capacity allocator.
// Used by pmca_cell and prefix_match_capacity_allocator; no dependencies.
`timescale 1ns / 1ps

package pmca_pkg;

    // table size and derived widths
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // compare width: holds the 6-bit slot field, any index and ENTRIES itself
    localparam int CMP_W   = ((IDX_W > 6) ? IDX_W : 6) + 1;

    localparam int ADDR_W  = 32;
    localparam int PLEN_W  = 6;
    localparam int CAP_W   = 16;
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_REQUEST = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_NONE_FREE   = 2'd1;
    localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

    // operation broadcast to the cells
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_RELEASE,
        OP_INC
    } op_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] network_base;
        logic [PLEN_W-1:0] prefix_len;
        logic [CAP_W-1:0]  capacity;
        logic [5:0]        entry_index;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] granted_index;
    } out_t;

    // command from the controller to every cell
    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] net;
        logic [PLEN_W-1:0] plen;
        logic [CAP_W-1:0]  cap;
    } cmd_t;

    // search token that walks down the chain
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  best_idx;
        logic [PLEN_W-1:0] best_len;
    } tok_t;

    // network mask for a prefix length of 0..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        prefix_mask = ~({ADDR_W{1'b1}} >> plen);
    endfunction

endpackage

### sv/prefix_match_capacity_allocator.sv
// Top level of the prefix match capacity allocator: controller plus a chain
// of pmca_cell slots. Depends on pmca_pkg and pmca_cell.
//
//   port     dir  meaning
//   start    in   request present; taken when busy is low
//   busy     out  a request is being worked on
//   req      in   request payload (pmca_pkg::in_t)
//   done     out  result strobe, high for one cycle
//   result   out  result payload (pmca_pkg::out_t)
//
// Load, release and unused mode: the request goes from idle to the execute
// state and back to idle. Allocation: the search token visits one slot per
// cycle along the chain, then the winning slot's count is bumped.
// Reset clears all valid marks and counts at once; no clearing pass.
// Every result is signalled for one cycle on done; the result payload is held until the next result.
`timescale 1ns / 1ps

module prefix_match_capacity_allocator
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pmca_pkg::in_t   req,
    output logic            done,
    output pmca_pkg::out_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EXEC
    } state_t;

    state_t                          state_reg;
    pmca_pkg::cmd_t                  cmd_reg;
    logic [pmca_pkg::ADDR_W-1:0]     addr_reg;
    logic                            launch_reg;
    logic                            rel_chk_reg;
    logic [1:0]                      stat_reg;
    logic [5:0]                      grant_reg;
    logic                            done_reg;
    pmca_pkg::out_t                  result_reg;

    pmca_pkg::tok_t                  chain [pmca_pkg::ENTRIES+1];
    logic [pmca_pkg::ENTRIES-1:0]    rel_vec;

    logic                            accept;
    logic [pmca_pkg::CMP_W-1:0]      idx_ext;
    logic                            idx_ok;
    logic [pmca_pkg::PLEN_W-1:0]     plen_sat;
    logic [pmca_pkg::CMP_W-1:0]      best_ext;
    logic [1:0]                      exec_status;

    assign accept = start && !busy;

    // slot number range check and prefix saturation
    assign idx_ext  = pmca_pkg::CMP_W'(req.entry_index);
    assign idx_ok   = idx_ext < pmca_pkg::CMP_W'(pmca_pkg::ENTRIES);
    assign plen_sat = (req.prefix_len > pmca_pkg::PLEN_MAX) ? pmca_pkg::PLEN_MAX
                                                            : req.prefix_len;
    assign best_ext = pmca_pkg::CMP_W'(chain[pmca_pkg::ENTRIES].best_idx);

    // status of the executing request
    assign exec_status = rel_chk_reg ? ((|rel_vec) ? pmca_pkg::ST_DONE
                                                   : pmca_pkg::ST_BAD_RELEASE)
                                     : stat_reg;

    // head of the chain: a fresh token, nothing found yet
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = launch_reg;
    end

    // row of slots
    for (genvar i = 0; i < pmca_pkg::ENTRIES; i++)
    begin : g_cell
        pmca_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (pmca_pkg::IDX_W'(i)),
            .cmd        (cmd_reg),
            .addr       (addr_reg),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1]),
            .rel_ok     (rel_vec[i])
        );
    end

    // controller state, request payload and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            addr_reg    <= '0;
            launch_reg  <= 1'b0;
            rel_chk_reg <= 1'b0;
            stat_reg    <= pmca_pkg::ST_DONE;
            grant_reg   <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            launch_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // capture request payload
                        addr_reg     <= req.address;
                        cmd_reg.idx  <= idx_ext[pmca_pkg::IDX_W-1:0];
                        cmd_reg.net  <= req.network_base & pmca_pkg::prefix_mask(plen_sat);
                        cmd_reg.plen <= plen_sat;
                        cmd_reg.cap  <= req.capacity;
                        rel_chk_reg  <= (req.mode == pmca_pkg::MODE_RELEASE);
                        stat_reg     <= pmca_pkg::ST_DONE;
                        grant_reg    <= '0;
                        state_reg    <= S_EXEC;
                        priority if (req.mode == pmca_pkg::MODE_REQUEST)
                        begin
                            cmd_reg.op <= pmca_pkg::OP_NONE;
                            launch_reg <= 1'b1;
                            state_reg  <= S_SWEEP;
                        end
                        else if ((req.mode == pmca_pkg::MODE_LOAD) && idx_ok)
                        begin
                            cmd_reg.op <= pmca_pkg::OP_LOAD;
                        end
                        else if ((req.mode == pmca_pkg::MODE_RELEASE) && idx_ok)
                        begin
                            cmd_reg.op <= pmca_pkg::OP_RELEASE;
                        end
                        else
                        begin
                            cmd_reg.op <= pmca_pkg::OP_NONE;
                        end
                    end
                end
                S_SWEEP:
                begin
                    // token left the last slot: claim the winner, if one was found
                    if (chain[pmca_pkg::ENTRIES].valid)
                    begin
                        state_reg   <= S_EXEC;
                        cmd_reg.idx <= chain[pmca_pkg::ENTRIES].best_idx;
                        if (chain[pmca_pkg::ENTRIES].found)
                        begin
                            cmd_reg.op <= pmca_pkg::OP_INC;
                            stat_reg   <= pmca_pkg::ST_DONE;
                            grant_reg  <= best_ext[5:0];
                        end
                        else
                        begin
                            stat_reg   <= pmca_pkg::ST_NONE_FREE;
                            grant_reg  <= '0;
                        end
                    end
                end
                S_EXEC:
                begin
                    cmd_reg.op               <= pmca_pkg::OP_NONE;
                    done_reg                 <= 1'b1;
                    result_reg.status        <= exec_status;
                    result_reg.granted_index <= grant_reg;
                    state_reg                <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sv/pmca_cell.sv
// One table slot: holds network, prefix, capacity and in-use count, and
// passes the search token on to the next slot. Depends on pmca_pkg.
`timescale 1ns / 1ps

module pmca_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pmca_pkg::IDX_W-1:0]    cell_index,
    input  pmca_pkg::cmd_t                cmd,
    input  logic [pmca_pkg::ADDR_W-1:0]   addr,
    input  pmca_pkg::tok_t                tok_in,
    output pmca_pkg::tok_t                tok_out,
    output logic                          rel_ok
);

    logic                          valid_reg;
    logic [pmca_pkg::ADDR_W-1:0]   net_reg;
    logic [pmca_pkg::PLEN_W-1:0]   plen_reg;
    logic [pmca_pkg::CAP_W-1:0]    cap_reg;
    logic [pmca_pkg::CAP_W-1:0]    used_reg;
    pmca_pkg::tok_t                tok_reg;
    pmca_pkg::tok_t                tok_next;

    logic sel;
    logic hit;
    logic take;

    // slot addressed by the current command
    assign sel = (cmd.op != pmca_pkg::OP_NONE) && (cmd.idx == cell_index);

    // release succeeds only on a valid slot with users
    assign rel_ok = sel && (cmd.op == pmca_pkg::OP_RELEASE) && valid_reg
                    && (used_reg != '0);

    // slot covers the address and has room
    assign hit = valid_reg && (used_reg < cap_reg)
                 && ((addr & pmca_pkg::prefix_mask(plen_reg)) == net_reg);

    // earlier slots win ties, so only a strictly shorter prefix replaces
    assign take = tok_in.valid && hit && (!tok_in.found || (plen_reg < tok_in.best_len));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_idx = cell_index;
            tok_next.best_len = plen_reg;
        end
    end

    // slot contents and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            used_reg  <= '0;
        end
        else if (sel)
        begin
            unique case (cmd.op)
                pmca_pkg::OP_LOAD:
                begin
                    valid_reg <= 1'b1;
                    used_reg  <= '0;
                end
                pmca_pkg::OP_RELEASE:
                begin
                    if (rel_ok)
                    begin
                        used_reg <= used_reg - pmca_pkg::CAP_W'(1);
                    end
                end
                pmca_pkg::OP_INC:
                begin
                    used_reg <= used_reg + pmca_pkg::CAP_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload of a load
    always_ff @(posedge clk)
    begin
        if (sel && (cmd.op == pmca_pkg::OP_LOAD))
        begin
            net_reg  <= cmd.net;
            plen_reg <= cmd.plen;
            cap_reg  <= cmd.cap;
        end
    end

    // token stage toward the next slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
